@@ rtl/ffa_pkg.sv @@
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types and constants of the first-fit bitmap allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

	localparam int ENTRY_W   = 10;
	localparam int COUNT_W   = 11;
	localparam int WORD_BITS = 32;
	localparam int BIT_W     = 5;

	localparam logic [COUNT_W-1:0] COUNT_MAX     = 11'd2047;
	localparam logic [COUNT_W-1:0] COUNT_RESET   = 11'd1024;
	localparam logic [COUNT_W-1:0] ENTRIES_RESET = 11'd1024;

	localparam logic OP_ALLOC   = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	localparam logic [1:0] ST_DONE        = 2'd0;
	localparam logic [1:0] ST_NO_FREE     = 2'd1;
	localparam logic [1:0] ST_BAD_RELEASE = 2'd2;

	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] CFG_ENTRIES_IN_USE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_START_FREE     = 2'd1;

	typedef struct packed {
		logic               op;
		logic [ENTRY_W-1:0] entry;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [ENTRY_W-1:0] granted;
		logic [COUNT_W-1:0] free_left;
	} res_t;

	typedef struct packed {
		logic               valid;
		logic [COUNT_W-1:0] value;
	} cnt_load_t;

endpackage

@@ rtl/ffa_map_ram.sv @@
// ----------------------------------------------------------------------------
// ffa_map_ram
// Used-map storage: 32-bit words, one write port and one read port with
// registered read data.
// ----------------------------------------------------------------------------
module ffa_map_ram #(
	parameter int WORDS = 32,
	parameter int AW    = 5
) (
	input  logic                            clk,
	input  logic                            rd_en,
	input  logic [AW-1:0]                   rd_addr,
	output logic [ffa_pkg::WORD_BITS-1:0]   rd_data,
	input  logic                            wr_en,
	input  logic [AW-1:0]                   wr_addr,
	input  logic [ffa_pkg::WORD_BITS-1:0]   wr_data
);

	logic [ffa_pkg::WORD_BITS-1:0] mem [WORDS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ rtl/ffa_engine.sv @@
// ----------------------------------------------------------------------------
// ffa_engine
// Request sequencer: clears the map after reset, scans it word by word for
// an allocate, and does the read-modify-write of one word for a release.
// Holds the free counter.
// ----------------------------------------------------------------------------
module ffa_engine #(
	parameter int WORDS = 32,
	parameter int AW    = 5
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req_valid,
	output logic                                 req_ready,
	input  ffa_pkg::req_t                        req,
	input  logic [ffa_pkg::COUNT_W-1:0]          limit,
	input  ffa_pkg::cnt_load_t                   cnt_load,
	output logic                                 res_valid,
	input  logic                                 res_ready,
	output ffa_pkg::res_t                        res,
	output logic                                 ram_rd_en,
	output logic [AW-1:0]                        ram_rd_addr,
	input  logic [ffa_pkg::WORD_BITS-1:0]        ram_rd_data,
	output logic                                 ram_wr_en,
	output logic [AW-1:0]                        ram_wr_addr,
	output logic [ffa_pkg::WORD_BITS-1:0]        ram_wr_data
);

	typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_SCAN, S_RCHK, S_DONE} state_t;

	state_t                          state_q;
	logic [AW-1:0]                   clr_q;
	logic [AW-1:0]                   scan_w_q;
	logic [AW-1:0]                   rel_w_q;
	ffa_pkg::req_t                   req_q;
	ffa_pkg::res_t                   res_q;
	logic [ffa_pkg::COUNT_W-1:0]     count_q;

	logic [5:0]                      word_hi;
	logic [ffa_pkg::BIT_W-1:0]       word_lo;
	logic [31:0]                     w32;
	logic [31:0]                     hi32;
	logic [ffa_pkg::WORD_BITS-1:0]   vmask;
	logic [ffa_pkg::WORD_BITS-1:0]   free_bits;
	logic                            found;
	logic [ffa_pkg::BIT_W-1:0]       idx;
	logic                            next_has;
	logic [31:0]                     gidx;
	logic                            rel_ok;
	logic [ffa_pkg::COUNT_W-1:0]     cnt_dec;
	logic [ffa_pkg::COUNT_W-1:0]     cnt_inc;
	logic                            rel_word_ok;

	assign req_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	always_comb begin
		word_hi   = limit[10:5];
		word_lo   = limit[4:0];
		w32       = 32'(scan_w_q);
		hi32      = 32'(word_hi);
		if (w32 < hi32) begin
			vmask = '1;
		end else if (w32 == hi32) begin
			vmask = (32'd1 << word_lo) - 32'd1;
		end else begin
			vmask = '0;
		end
		free_bits = ~ram_rd_data & vmask;
		found     = |free_bits;
		idx       = '0;
		for (int b = ffa_pkg::WORD_BITS - 1; b >= 0; b--) begin
			if (free_bits[b]) begin
				idx = ffa_pkg::BIT_W'(b);
			end
		end
		next_has    = (w32 + 32'd1 < hi32) || ((w32 + 32'd1 == hi32) && (word_lo != '0));
		gidx        = (w32 << ffa_pkg::BIT_W) | 32'(idx);
		rel_ok      = ({1'b0, req_q.entry} < limit) && ram_rd_data[req_q.entry[4:0]];
		cnt_dec     = (count_q != '0) ? count_q - 11'd1 : count_q;
		cnt_inc     = (count_q != ffa_pkg::COUNT_MAX) ? count_q + 11'd1 : count_q;
		rel_word_ok = (32'(req.entry[9:5]) < WORDS);
	end

	always_comb begin
		ram_rd_en   = 1'b0;
		ram_rd_addr = '0;
		ram_wr_en   = 1'b0;
		ram_wr_addr = '0;
		ram_wr_data = '0;
		case (state_q)
			S_CLEAR: begin
				ram_wr_en   = 1'b1;
				ram_wr_addr = clr_q;
			end
			S_IDLE: begin
				if (req_valid) begin
					if (req.op == ffa_pkg::OP_ALLOC) begin
						ram_rd_en = 1'b1;
					end else begin
						ram_rd_en   = rel_word_ok;
						ram_rd_addr = AW'(req.entry[9:5]);
					end
				end
			end
			S_SCAN: begin
				if (found) begin
					ram_wr_en   = 1'b1;
					ram_wr_addr = scan_w_q;
					ram_wr_data = ram_rd_data | (32'd1 << idx);
				end else if (next_has) begin
					ram_rd_en   = 1'b1;
					ram_rd_addr = scan_w_q + AW'(1);
				end
			end
			S_RCHK: begin
				if (rel_ok) begin
					ram_wr_en   = 1'b1;
					ram_wr_addr = rel_w_q;
					ram_wr_data = ram_rd_data & ~(32'd1 << req_q.entry[4:0]);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			scan_w_q <= '0;
			rel_w_q  <= '0;
			req_q    <= '0;
			res_q    <= '0;
			count_q  <= ffa_pkg::COUNT_RESET;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (32'(clr_q) == WORDS - 1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						req_q    <= req;
						scan_w_q <= '0;
						rel_w_q  <= AW'(req.entry[9:5]);
						state_q  <= (req.op == ffa_pkg::OP_ALLOC) ? S_SCAN : S_RCHK;
					end
				end
				S_SCAN: begin
					if (found) begin
						count_q           <= cnt_dec;
						res_q.status      <= ffa_pkg::ST_DONE;
						res_q.granted     <= gidx[ffa_pkg::ENTRY_W-1:0];
						res_q.free_left   <= cnt_dec;
						state_q           <= S_DONE;
					end else if (next_has) begin
						scan_w_q <= scan_w_q + AW'(1);
					end else begin
						res_q.status    <= ffa_pkg::ST_NO_FREE;
						res_q.granted   <= '0;
						res_q.free_left <= count_q;
						state_q         <= S_DONE;
					end
				end
				S_RCHK: begin
					if (rel_ok) begin
						count_q         <= cnt_inc;
						res_q.status    <= ffa_pkg::ST_DONE;
						res_q.granted   <= req_q.entry;
						res_q.free_left <= cnt_inc;
					end else begin
						res_q.status    <= ffa_pkg::ST_BAD_RELEASE;
						res_q.granted   <= '0;
						res_q.free_left <= count_q;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cnt_load.valid) begin
				count_q <= cnt_load.value;
			end
		end
	end

endmodule

@@ rtl/bitmap_first_free_allocator.sv @@
// ----------------------------------------------------------------------------
// bitmap_first_free_allocator
// First-fit allocator over a one-bit-per-entry used map with a free counter.
// ----------------------------------------------------------------------------
// The used map lives in a memory of 32-bit words with a registered read. After
// reset a clearing pass writes every word to zero, one word a cycle, during
// which no request beat is taken; register writes are taken at all times. One
// request is worked on at a time. An allocate scans the map from word zero,
// one word a cycle, and stops at the first free entry or at the last word
// below entries_in_use (capped at ENTRIES, with at least one word read). The
// next request beat is taken only once its result has left the engine. A
// release reads its one word and rewrites it only when the entry is below
// the capped entries_in_use and is marked used. The result sits in an output
// register, so the next request is taken while a result still waits; the
// engine stalls only when a second result is ready before the first is taken.
// ----------------------------------------------------------------------------
module bitmap_first_free_allocator #(
	parameter int ENTRIES = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Request channel.
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [15:0]                         s_axis_tdata,  // entry_number[9:0], zero fill
	input  logic [0:0]                          s_axis_tuser,  // op[0]
	// Result channel.
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [23:0]                         m_axis_tdata,  // granted_entry[9:0], free_left[20:10]
	output logic [1:0]                          m_axis_tuser,  // status[1:0]
	// Register write channel.
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ffa_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [ffa_pkg::COUNT_W-1:0]         cfg_data
);

	localparam int WORDS = (ENTRIES + ffa_pkg::WORD_BITS - 1) / ffa_pkg::WORD_BITS;
	localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

	logic [ffa_pkg::COUNT_W-1:0]   entries_q;
	logic [ffa_pkg::COUNT_W-1:0]   limit;
	ffa_pkg::cnt_load_t            cnt_load;
	ffa_pkg::req_t                 req;
	ffa_pkg::res_t                 res;
	ffa_pkg::res_t                 out_q;
	logic                          out_valid_q;
	logic                          res_valid;
	logic                          res_ready;
	logic                          ram_rd_en;
	logic [AW-1:0]                 ram_rd_addr;
	logic [ffa_pkg::WORD_BITS-1:0] ram_rd_data;
	logic                          ram_wr_en;
	logic [AW-1:0]                 ram_wr_addr;
	logic [ffa_pkg::WORD_BITS-1:0] ram_wr_data;

	assign cfg_ready      = 1'b1;
	assign cnt_load.valid = cfg_valid && (cfg_index == ffa_pkg::CFG_START_FREE);
	assign cnt_load.value = cfg_data;
	assign limit          = (32'(entries_q) > ENTRIES) ? ffa_pkg::COUNT_W'(ENTRIES) : entries_q;

	assign req.op    = s_axis_tuser[0];
	assign req.entry = s_axis_tdata[ffa_pkg::ENTRY_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= ffa_pkg::ENTRIES_RESET;
		end else if (cfg_valid && (cfg_index == ffa_pkg::CFG_ENTRIES_IN_USE)) begin
			entries_q <= cfg_data;
		end
	end

	ffa_map_ram #(
		.WORDS (WORDS),
		.AW    (AW)
	) u_map (
		.clk     (clk),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data)
	);

	ffa_engine #(
		.WORDS (WORDS),
		.AW    (AW)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (s_axis_tvalid),
		.req_ready   (s_axis_tready),
		.req         (req),
		.limit       (limit),
		.cnt_load    (cnt_load),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res),
		.ram_rd_en   (ram_rd_en),
		.ram_rd_addr (ram_rd_addr),
		.ram_rd_data (ram_rd_data),
		.ram_wr_en   (ram_wr_en),
		.ram_wr_addr (ram_wr_addr),
		.ram_wr_data (ram_wr_data)
	);

	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
			out_q       <= res;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.status;
	assign m_axis_tdata  = {3'b000, out_q.free_left, out_q.granted};

`ifndef ASSERT_OFF
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request taken while another is in progress");

	a_fail_grants_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != ffa_pkg::ST_DONE) |-> m_axis_tdata[9:0] == 10'd0)
		else $error("failed request carries a nonzero entry");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("engine dropped a result waiting for the output register");

	a_no_write_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !$past(res_valid) && (res.status != ffa_pkg::ST_DONE) |->
		$past(!ram_wr_en))
		else $error("map written by a failed request");
`endif

endmodule
